// File: rtl/cbm_pkg.sv
// Shared types, constants and helpers for the cartridge bank mapper.
// Depends on nothing; cbm_mod_unit and cartridge_bank_mapper use it.
package cbm_pkg;

   // ROM bank register width
   localparam int ROM_BANK_BITS = 9;
   // working width of bank arithmetic and of the modulo unit dividend
   localparam int BANK_WORK_W   = 9;
   localparam int BANK_COUNT_W  = 10;
   localparam int RAM_MASK_W    = 17;
   localparam int PHYS_W        = 23;
   localparam int ROM_OFS_W     = 14;
   localparam int RAM_OFS_W     = 13;
   localparam int STEP_CNT_W    = $clog2(BANK_WORK_W + 1);

   // mapper kinds
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_MBC1  = 3'd1;
   localparam logic [2:0] KIND_MBC1M = 3'd2;
   localparam logic [2:0] KIND_MBC2  = 3'd3;
   localparam logic [2:0] KIND_MBC3  = 3'd4;
   localparam logic [2:0] KIND_MBC5  = 3'd5;

   // result targets
   localparam logic [1:0] TGT_ROM   = 2'd0;
   localparam logic [1:0] TGT_RAM   = 2'd1;
   localparam logic [1:0] TGT_CLOCK = 2'd2;
   localparam logic [1:0] TGT_OPEN  = 2'd3;

   // bus commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_MAPPER_KIND    = 2'd0;
   localparam logic [1:0] CSR_ROM_BANK_COUNT = 2'd1;
   localparam logic [1:0] CSR_RAM_SIZE_MASK  = 2'd2;

   // request to the modulo unit
   typedef struct packed {
      logic                    start;
      logic [BANK_WORK_W-1:0]  dividend;
      logic [BANK_COUNT_W-1:0] divisor;
   } mod_req_type;

   // answer from the modulo unit
   typedef struct packed {
      logic                   done;
      logic [BANK_WORK_W-1:0] remainder;
   } mod_rsp_type;

   function automatic logic kind_known(input logic [2:0] kind);
      return (kind == KIND_MBC1) || (kind == KIND_MBC1M) || (kind == KIND_MBC2) ||
             (kind == KIND_MBC3) || (kind == KIND_MBC5);
   endfunction

endpackage

// File: rtl/cbm_if.sv
// Handshake channel interfaces of the cartridge bank mapper.
// Standalone; field widths match the constants in cbm_pkg.
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, command, address, data, input ready);
   modport sink   (input valid, command, address, data, output ready);
endinterface

interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  target;
   logic [22:0] phys_address;
   logic        write_enable;
   logic [7:0]  write_data;
   logic        ram_flush;

   modport source (output valid, target, phys_address, write_enable, write_data, ram_flush,
                   input ready);
   modport sink   (input valid, target, phys_address, write_enable, write_data, ram_flush,
                   output ready);
endinterface

interface cbm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [16:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/cbm_mod_unit.sv
// Bit-serial modulo unit: remainder of a bank number by the ROM bank count.
// One restoring step per cycle, MSB first. Depends on cbm_pkg.
module cbm_mod_unit (
   input  logic                clock,
   input  logic                reset,
   input  cbm_pkg::mod_req_type req,
   output cbm_pkg::mod_rsp_type rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic                                zero_ff, zero_in;
   logic [cbm_pkg::STEP_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [cbm_pkg::BANK_COUNT_W-1:0]    rem_ff, rem_in;
   logic [cbm_pkg::BANK_WORK_W-1:0]     dvd_ff, dvd_in;
   logic [cbm_pkg::BANK_WORK_W-1:0]     orig_ff, orig_in;
   logic [cbm_pkg::BANK_COUNT_W-1:0]    div_ff, div_in;
   logic [cbm_pkg::BANK_COUNT_W:0]      trial;

   // one shift-in and trial subtract
   assign trial = {rem_ff, dvd_ff[cbm_pkg::BANK_WORK_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      orig_in = orig_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         zero_in = (req.divisor == '0);
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = req.dividend;
         orig_in = req.dividend;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = cbm_pkg::BANK_COUNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[cbm_pkg::BANK_COUNT_W-1:0];
         end
         dvd_in = {dvd_ff[cbm_pkg::BANK_WORK_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cbm_pkg::STEP_CNT_W'(cbm_pkg::BANK_WORK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      orig_ff <= orig_in;
      div_ff  <= div_in;
   end

   // a zero bank count leaves the bank number unreduced
   assign rsp.done      = done_ff;
   assign rsp.remainder = zero_ff ? orig_ff : rem_ff[cbm_pkg::BANK_WORK_W-1:0];

endmodule

// File: rtl/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: bank registers, access decode,
// result register. Depends on cbm_pkg, cbm_if and cbm_mod_unit.
//
//  channel | dir | handshake     | payload
//  req_ch  | in  | valid/ready   | command, address, data
//  rsp_ch  | out | valid/ready   | target, phys_address, write_enable, write_data, ram_flush
//  csr_ch  | in  | valid/ready   | index, wdata (always ready)
//
// A ROM read passes through the bit-serial modulo unit, which reduces the bank
// number modulo the bank count; every other access goes from accept straight to
// the done state. One item is in flight at a time.
// reset is synchronous and restores control registers and bank state to power-up values.
// A finished item waits in the result register while the next item is taken;
// a third item waits until the result register frees up.
module cartridge_bank_mapper (
   input  logic      clock,
   input  logic      reset,
   cbm_req_if.sink   req_ch,
   cbm_rsp_if.source rsp_ch,
   cbm_csr_if.sink   csr_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int BW = cbm_pkg::BANK_WORK_W;
   localparam int RB = cbm_pkg::ROM_BANK_BITS;

   // configuration
   logic [2:0]                         kind_ff;
   logic [cbm_pkg::BANK_COUNT_W-1:0]   bank_count_ff;
   logic [cbm_pkg::RAM_MASK_W-1:0]     ram_mask_ff;

   // bank state
   logic          ram_en_ff, ram_en_in;
   logic [RB-1:0] rom_bank_ff, rom_bank_in;
   logic [3:0]    ram_bank_ff, ram_bank_in;
   logic          mode_ff, mode_in;
   logic [6:0]    low_bank_ff, low_bank_in;
   logic          dirty_ff, dirty_in;

   // sequencer and pending item
   logic [1:0]                      state_ff, state_in;
   logic [1:0]                      pend_target_ff, pend_target_in;
   logic [cbm_pkg::PHYS_W-1:0]      pend_phys_ff, pend_phys_in;
   logic                            pend_we_ff, pend_we_in;
   logic [7:0]                      pend_wdata_ff, pend_wdata_in;
   logic                            pend_flush_ff, pend_flush_in;
   logic [cbm_pkg::ROM_OFS_W-1:0]   pend_lo_ff, pend_lo_in;

   // result register
   logic                            out_valid_ff, out_valid_in;
   logic [1:0]                      out_target_ff;
   logic [cbm_pkg::PHYS_W-1:0]      out_phys_ff;
   logic                            out_we_ff;
   logic [7:0]                      out_wdata_ff;
   logic                            out_flush_ff;

   cbm_pkg::mod_req_type mod_req;
   cbm_pkg::mod_rsp_type mod_rsp;

   logic          accept;
   logic          out_load;
   logic [15:0]   addr;
   logic [7:0]    din;
   logic          known;
   logic          is_mbc1;
   logic [BW-1:0] rb_ext;
   logic [BW-1:0] rb_tmp;
   logic [BW-1:0] low_tmp;
   logic          refresh;
   logic          enable_write;
   logic [cbm_pkg::RAM_MASK_W-1:0] bank_ofs;
   logic [cbm_pkg::PHYS_W-1:0]     ram_ofs;
   logic [3:0]    clk_idx;
   logic [7:0]    clk_data;

   assign accept     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign addr       = req_ch.address;
   assign din        = req_ch.data;
   assign known      = cbm_pkg::kind_known(kind_ff);
   assign is_mbc1    = (kind_ff == cbm_pkg::KIND_MBC1) || (kind_ff == cbm_pkg::KIND_MBC1M);
   assign rb_ext     = BW'(rom_bank_ff);
   assign out_load   = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ch.ready);

   // banked RAM offset
   assign bank_ofs = cbm_pkg::RAM_MASK_W'({ram_bank_ff, 13'h0000}) & ram_mask_ff;
   assign ram_ofs  = cbm_pkg::PHYS_W'(bank_ofs) + cbm_pkg::PHYS_W'(addr[12:0]);

   // clock register index and field masks
   assign clk_idx = ram_bank_ff - 4'd8;
   always_comb begin
      unique case (clk_idx)
         4'd0, 4'd1: clk_data = din & 8'h3F;
         4'd2:       clk_data = din & 8'h1F;
         4'd4:       clk_data = din & 8'hC1;
         default:    clk_data = din;
      endcase
   end

   // mapper register writes
   always_comb begin
      ram_en_in    = ram_en_ff;
      rom_bank_in  = rom_bank_ff;
      ram_bank_in  = ram_bank_ff;
      mode_in      = mode_ff;
      low_bank_in  = low_bank_ff;
      rb_tmp       = rb_ext;
      refresh      = 1'b0;
      enable_write = 1'b0;
      if (accept && req_ch.command == cbm_pkg::CMD_WRITE && !addr[15] && known) begin
         if (kind_ff == cbm_pkg::KIND_MBC2) begin
            if (addr[14] == 1'b0) begin
               if (addr[8]) begin
                  rb_tmp = (din[3:0] == 4'h0) ? BW'(1) : BW'(din[3:0]);
               end else begin
                  ram_en_in    = (din[3:0] == 4'hA);
                  enable_write = 1'b1;
               end
            end
         end else begin
            unique case (addr[14:13])
               2'b00: begin
                  ram_en_in    = (kind_ff == cbm_pkg::KIND_MBC5) ? (din == 8'h0A)
                                                                 : (din[3:0] == 4'hA);
                  enable_write = 1'b1;
               end
               2'b01: begin
                  priority if (kind_ff == cbm_pkg::KIND_MBC1) begin
                     rb_tmp = (rb_ext & BW'(9'h0E0)) | BW'(din[4:0]);
                     if (din[4:0] == 5'd0) rb_tmp[0] = 1'b1;
                  end else if (kind_ff == cbm_pkg::KIND_MBC1M) begin
                     rb_tmp = (rb_ext & BW'(9'h0F0)) | BW'(din[3:0]);
                     if (din[4:0] == 5'd0) rb_tmp[0] = 1'b1;
                  end else if (kind_ff == cbm_pkg::KIND_MBC3) begin
                     rb_tmp = (din[6:0] == 7'd0) ? BW'(1) : BW'(din[6:0]);
                  end else if (!addr[12]) begin
                     rb_tmp = (rb_ext & BW'(9'h100)) | BW'(din);
                  end else begin
                     rb_tmp = (rb_ext & BW'(9'h0FF)) | BW'({din[0], 8'h00});
                  end
               end
               2'b10: begin
                  if (kind_ff == cbm_pkg::KIND_MBC3 || kind_ff == cbm_pkg::KIND_MBC5) begin
                     ram_bank_in = din[3:0];
                  end else begin
                     ram_bank_in = {2'b00, din[1:0]};
                     if (kind_ff == cbm_pkg::KIND_MBC1M) begin
                        rb_tmp = (rb_ext & BW'(9'h00F)) | BW'({din[1:0], 4'h0});
                     end else begin
                        rb_tmp = (rb_ext & BW'(9'h01F)) | BW'({din[1:0], 5'h00});
                     end
                     refresh = 1'b1;
                  end
               end
               default: begin
                  if (is_mbc1) begin
                     mode_in = din[0];
                     refresh = 1'b1;
                  end
               end
            endcase
         end
      end
      rom_bank_in = rb_tmp[RB-1:0];
      // bank seen at 0000-3FFF in MBC1 mode one
      low_tmp = BW'(rom_bank_in) & ((kind_ff == cbm_pkg::KIND_MBC1M) ? BW'(9'h030)
                                                                      : BW'(9'h060));
      if (refresh) begin
         low_bank_in = mode_in ? low_tmp[6:0] : 7'd0;
      end
   end

   // access decode, dirty tracking and sequencer
   always_comb begin
      state_in       = state_ff;
      pend_target_in = pend_target_ff;
      pend_phys_in   = pend_phys_ff;
      pend_we_in     = pend_we_ff;
      pend_wdata_in  = pend_wdata_ff;
      pend_flush_in  = pend_flush_ff;
      pend_lo_in     = pend_lo_ff;
      dirty_in       = dirty_ff;
      mod_req.start    = 1'b0;
      mod_req.dividend = addr[14] ? rb_ext : BW'(low_bank_ff);
      mod_req.divisor  = bank_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_target_in = cbm_pkg::TGT_OPEN;
               pend_phys_in   = '0;
               pend_we_in     = 1'b0;
               pend_wdata_in  = 8'h00;
               pend_flush_in  = 1'b0;
               pend_lo_in     = addr[13:0];
               state_in       = ST_DONE;
               if (!addr[15]) begin
                  if (req_ch.command == cbm_pkg::CMD_WRITE) begin
                     if (enable_write && !ram_en_in) begin
                        pend_flush_in = dirty_ff;
                        dirty_in      = 1'b0;
                     end
                  end else begin
                     pend_target_in = cbm_pkg::TGT_ROM;
                     mod_req.start  = 1'b1;
                     state_in       = ST_CALC;
                  end
               end else if (addr[15:13] == 3'b101 && known && ram_en_ff) begin
                  if (req_ch.command == cbm_pkg::CMD_WRITE) dirty_in = 1'b1;
                  priority if (kind_ff == cbm_pkg::KIND_MBC2) begin
                     pend_target_in = cbm_pkg::TGT_RAM;
                     pend_phys_in   = cbm_pkg::PHYS_W'(addr[8:0]);
                     pend_wdata_in  = din | 8'hF0;
                  end else if (is_mbc1) begin
                     pend_target_in = cbm_pkg::TGT_RAM;
                     pend_phys_in   = mode_ff ? ram_ofs : cbm_pkg::PHYS_W'(addr[12:0]);
                     pend_wdata_in  = din;
                  end else if (kind_ff == cbm_pkg::KIND_MBC5 || ram_bank_ff < 4'd4) begin
                     pend_target_in = cbm_pkg::TGT_RAM;
                     pend_phys_in   = ram_ofs;
                     pend_wdata_in  = din;
                  end else if (ram_bank_ff >= 4'd8 && ram_bank_ff <= 4'd12) begin
                     pend_target_in = cbm_pkg::TGT_CLOCK;
                     if (req_ch.command == cbm_pkg::CMD_WRITE) begin
                        pend_phys_in  = cbm_pkg::PHYS_W'(clk_idx);
                        pend_wdata_in = clk_data;
                     end else begin
                        pend_phys_in  = cbm_pkg::PHYS_W'(clk_idx + 4'd5);
                     end
                  end
                  if (pend_target_in != cbm_pkg::TGT_OPEN &&
                      req_ch.command == cbm_pkg::CMD_WRITE) begin
                     pend_we_in = 1'b1;
                  end
               end
               if (!pend_we_in) pend_wdata_in = 8'h00;
            end
         end
         ST_CALC: begin
            if (mod_rsp.done) begin
               pend_phys_in = {mod_rsp.remainder, pend_lo_ff};
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ch.ready) out_valid_in = 1'b0;
      if (out_load) out_valid_in = 1'b1;
   end

   cbm_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= cbm_pkg::KIND_NONE;
         bank_count_ff <= cbm_pkg::BANK_COUNT_W'(2);
         ram_mask_ff   <= cbm_pkg::RAM_MASK_W'(8191);
         ram_en_ff     <= 1'b0;
         rom_bank_ff   <= RB'(1);
         ram_bank_ff   <= 4'd0;
         mode_ff       <= 1'b0;
         low_bank_ff   <= 7'd0;
         dirty_ff      <= 1'b0;
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
      end else begin
         // configuration writes; indexes beyond the list are dropped
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               cbm_pkg::CSR_MAPPER_KIND:    kind_ff       <= csr_ch.wdata[2:0];
               cbm_pkg::CSR_ROM_BANK_COUNT: bank_count_ff <= csr_ch.wdata[9:0];
               cbm_pkg::CSR_RAM_SIZE_MASK:  ram_mask_ff   <= csr_ch.wdata;
               default: ;
            endcase
         end
         ram_en_ff    <= ram_en_in;
         rom_bank_ff  <= rom_bank_in;
         ram_bank_ff  <= ram_bank_in;
         mode_ff      <= mode_in;
         low_bank_ff  <= low_bank_in;
         dirty_ff     <= dirty_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      pend_target_ff <= pend_target_in;
      pend_phys_ff   <= pend_phys_in;
      pend_we_ff     <= pend_we_in;
      pend_wdata_ff  <= pend_wdata_in;
      pend_flush_ff  <= pend_flush_in;
      pend_lo_ff     <= pend_lo_in;
      if (out_load) begin
         out_target_ff <= pend_target_ff;
         out_phys_ff   <= pend_phys_ff;
         out_we_ff     <= pend_we_ff;
         out_wdata_ff  <= pend_wdata_ff;
         out_flush_ff  <= pend_flush_ff;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.target       = out_target_ff;
   assign rsp_ch.phys_address = out_phys_ff;
   assign rsp_ch.write_enable = out_we_ff;
   assign rsp_ch.write_data   = out_wdata_ff;
   assign rsp_ch.ram_flush    = out_flush_ff;

endmodule
